// File: sv/encoder_position_move_controller_defines.svh
// assertion macros shared by the checker
`ifndef ENCODER_POSITION_MOVE_CONTROLLER_DEFINES_SVH
`define ENCODER_POSITION_MOVE_CONTROLLER_DEFINES_SVH

// same-cycle implication, clocked on clock, quiet during reset
`define EMP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("emp assertion failed");

// next-cycle implication
`define EMP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("emp assertion failed");

`endif

// File: sv/emp_pkg.sv
package emp_pkg;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_MOVE = 2'd1,
      OP_STOP = 2'd2
   } opcode_type;

   localparam logic [1:0] DRIVE_HALT = 2'd0;
   localparam logic [1:0] DRIVE_POS  = 2'd1;
   localparam logic [1:0] DRIVE_NEG  = 2'd2;

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_POS_CHANGE = 3'd1;
   localparam logic [2:0] EV_REACHED    = 3'd2;
   localparam logic [2:0] EV_SETTLE     = 3'd3;
   localparam logic [2:0] EV_UNEXPECTED = 3'd4;
   localparam logic [2:0] EV_STALL      = 3'd5;

   localparam logic [1:0] CSR_STALL_TICKS  = 2'd0;
   localparam logic [1:0] CSR_SETTLE_TICKS = 2'd1;

   localparam logic [31:0] STALL_TICKS_RESET  = 32'd1000;
   localparam logic [31:0] SETTLE_TICKS_RESET = 32'd200;

   typedef struct packed {
      logic [31:0] stall_ticks;
      logic [31:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic [31:0] position;
      logic [31:0] target;
      logic [31:0] rest;
      logic        dir_positive;
      logic        moving;
      logic        reached;
      logic [1:0]  drive;
      logic [31:0] since_change;
      logic [31:0] since_reached;
   } state_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] rest_position;
      logic [31:0] position_now;
      logic        in_motion;
      logic        command_accepted;
      logic [1:0]  drive;
   } result_type;

endpackage

// File: sv/emp_csr.sv
module emp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output emp_pkg::cfg_type  cfg
);
   import emp_pkg::*;

   logic [31:0] stall_ticks_ff;
   logic [31:0] stall_ticks_in;
   logic [31:0] settle_ticks_ff;
   logic [31:0] settle_ticks_in;

   always_comb begin
      stall_ticks_in  = stall_ticks_ff;
      settle_ticks_in = settle_ticks_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STALL_TICKS:  stall_ticks_in  = csr_wdata;
            CSR_SETTLE_TICKS: settle_ticks_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_ticks_ff  <= STALL_TICKS_RESET;
         settle_ticks_ff <= SETTLE_TICKS_RESET;
      end else begin
         stall_ticks_ff  <= stall_ticks_in;
         settle_ticks_ff <= settle_ticks_in;
      end
   end

   assign cfg.stall_ticks  = stall_ticks_ff;
   assign cfg.settle_ticks = settle_ticks_ff;

endmodule

// File: sv/emp_step.sv
module emp_step (
   input  emp_pkg::state_type  cur,
   input  emp_pkg::cfg_type    cfg,
   input  logic [1:0]          opcode,
   input  logic [31:0]         target_position,
   input  logic [31:0]         encoder_count,
   output emp_pkg::state_type  nxt,
   output emp_pkg::result_type res
);
   import emp_pkg::*;

   always_comb begin
      logic accepted;
      logic passed;
      logic [2:0] ev;

      nxt      = cur;
      accepted = 1'b0;
      ev       = EV_NONE;

      // both tick counters saturate at all ones
      nxt.since_change  = (cur.since_change == '1) ? cur.since_change
                                                    : cur.since_change + 32'd1;
      nxt.since_reached = (cur.since_reached == '1) ? cur.since_reached
                                                     : cur.since_reached + 32'd1;

      case (opcode)
         OP_MOVE: begin
            if (!cur.moving) begin
               nxt.moving       = 1'b1;
               nxt.reached      = 1'b0;
               nxt.target       = target_position;
               nxt.dir_positive = $signed(target_position) > $signed(cur.position);
               nxt.drive        = ($signed(target_position) > $signed(cur.position))
                                  ? DRIVE_POS : DRIVE_NEG;
               nxt.since_change = '0;
               accepted         = 1'b1;
            end
         end
         OP_STOP: begin
            if (cur.moving) begin
               nxt.target = cur.position;
               accepted   = 1'b1;
            end
         end
         default: ;
      endcase

      passed = nxt.dir_positive ? ($signed(encoder_count) > $signed(nxt.target))
                                : ($signed(encoder_count) < $signed(nxt.target));

      if (encoder_count != cur.position) begin
         nxt.position     = encoder_count;
         nxt.since_change = '0;
         ev               = EV_POS_CHANGE;
         if (nxt.moving && !nxt.reached) begin
            if (passed) begin
               nxt.reached       = 1'b1;
               nxt.since_reached = '0;
               nxt.drive         = DRIVE_HALT;
               ev                = EV_REACHED;
            end
         end else if (nxt.moving && nxt.reached
                      && nxt.since_reached <= cfg.settle_ticks) begin
            ev = EV_SETTLE;
         end else begin
            nxt.rest = encoder_count;
            ev       = EV_UNEXPECTED;
         end
      end else if (nxt.moving && nxt.since_change > cfg.stall_ticks) begin
         nxt.rest   = cur.position;
         nxt.moving = 1'b0;
         nxt.drive  = DRIVE_HALT;
         ev         = EV_STALL;
      end

      // settle window over: the move ends quietly
      if (nxt.moving && nxt.reached && nxt.since_reached > cfg.settle_ticks) begin
         nxt.moving = 1'b0;
         nxt.rest   = nxt.position;
      end

      res.drive            = nxt.drive;
      res.command_accepted = accepted;
      res.in_motion        = nxt.moving;
      res.position_now     = nxt.position;
      res.rest_position    = nxt.rest;
      res.event_res        = ev;
   end

endmodule

// File: sv/encoder_position_move_controller.sv
// Encoder positioner with stall detection, one request per motor tick.
// Request channel (req_): tuser carries the opcode (none, move, stop), tdata
// the move target and the encoder sample of the tick. Result channel (rsp_):
// one result per request with bridge drive, accept flag, moving flag, held
// position, rest position and an event code.
// Configuration (csr_): stall and settle tick limits, written while idle;
// an index beyond the two registers is ignored.
// A request taken into the input register is evaluated as a tick, and its
// result is registered in the result register once that register is free or
// being read. Throughput is one request per cycle while the receiver does not
// stall: the controller state feeds straight back from the result stage.
// Reset clears the controller state, drops both pipeline stages and loads the default
// limits (1000 stall ticks, 200 settle ticks).
// When the receiver stalls, the result register holds its value; the input
// register still takes one more request, after which req_tready falls.
module encoder_position_move_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // target_position [31:0], encoder_count [63:32]
   input  logic [1:0]  req_tuser,  // opcode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drive [1:0], command_accepted [2], in_motion [3], position_now [35:4],
   // rest_position [67:36], event_res [70:68], zero [71]
   output logic [71:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import emp_pkg::*;

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   state_type  step_nxt;
   result_type step_res;
   result_type res_ff;
   result_type res_in;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [1:0]  opcode_ff;
   logic [31:0] target_ff;
   logic [31:0] encoder_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic        advance;
   logic        take;

   emp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   emp_step u_step (
      .cur             (state_ff),
      .cfg             (cfg),
      .opcode          (opcode_ff),
      .target_position (target_ff),
      .encoder_count   (encoder_ff),
      .nxt             (step_nxt),
      .res             (step_res)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      state_in     = advance ? step_nxt : state_ff;
      res_in       = advance ? step_res : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         opcode_ff  <= req_tuser;
         target_ff  <= req_tdata[31:0];
         encoder_ff <= req_tdata[63:32];
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, res_ff};

endmodule

// File: sv/emp_checker.sv
`include "encoder_position_move_controller_defines.svh"

module emp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   import emp_pkg::*;

   logic [1:0] drive;
   logic       in_motion;
   logic [2:0] event_res;
   logic       same_rest;

   assign drive     = rsp_tdata[1:0];
   assign in_motion = rsp_tdata[3];
   assign event_res = rsp_tdata[70:68];
   assign same_rest = rsp_tdata[35:4] == rsp_tdata[67:36];

   // a stalled result must not change under the receiver
   `EMP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // the bridge only runs during a move
   `EMP_ASSERT_NOW(a_idle_halted, rsp_tvalid && !in_motion, drive == DRIVE_HALT)

   // a stall ends the move at the held position
   `EMP_ASSERT_NOW(a_stall_rest, rsp_tvalid && event_res == EV_STALL, !in_motion && same_rest)

   // reaching the target halts the bridge but keeps the settle window open
   `EMP_ASSERT_NOW(a_reach_halt, rsp_tvalid && event_res == EV_REACHED, in_motion && drive == DRIVE_HALT)

endmodule

bind encoder_position_move_controller emp_checker u_emp_checker (.*);

// File: dv/encoder_position_move_checker.sv
`timescale 1ns / 100ps

module encoder_position_move_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,  // target_position [31:0], encoder_count [63:32]
   input  logic [1:0]  req_tuser,  // opcode [1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drive [1:0], command_accepted [2], in_motion [3], position_now [35:4],
   // rest_position [67:36], event_res [70:68], zero [71]
   input  logic [71:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import emp_pkg::*;

   logic [31:0]        stall_limit;
   logic [31:0]        settle_limit;
   logic signed [31:0] position_q;
   logic signed [31:0] target_q;
   logic signed [31:0] rest_q;
   logic               dir_positive;
   logic               moving;
   logic               reached;
   logic [1:0]         drive_q;
   logic [31:0]        since_change;
   logic [31:0]        since_reached;
   result_type         due_results[$];
   int                 results_seen;

   initial begin
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result %0d, %s: got %h, expected %h",
               results_seen, what, got, want);
      fail_count++;
   endtask

   // one motor tick: command first, then the encoder sample
   task automatic predict_tick(input logic [1:0] op, input logic signed [31:0] tgt,
                               input logic signed [31:0] enc);
      result_type r;
      logic       accepted;
      logic [2:0] ev;
      logic       passed;
      accepted = 1'b0;
      ev       = EV_NONE;
      if (since_change != 32'hFFFF_FFFF) since_change = since_change + 1;
      if (since_reached != 32'hFFFF_FFFF) since_reached = since_reached + 1;

      if (op == OP_MOVE) begin
         if (!moving) begin
            moving       = 1'b1;
            reached      = 1'b0;
            target_q     = tgt;
            dir_positive = tgt > position_q;
            drive_q      = dir_positive ? DRIVE_POS : DRIVE_NEG;
            since_change = '0;
            accepted     = 1'b1;
         end
      end else if (op == OP_STOP) begin
         if (moving) begin
            target_q = position_q;
            accepted = 1'b1;
         end
      end

      if (enc != position_q) begin
         position_q   = enc;
         since_change = '0;
         ev           = EV_POS_CHANGE;
         if (moving && !reached) begin
            passed = dir_positive ? (position_q > target_q) : (position_q < target_q);
            if (passed) begin
               reached       = 1'b1;
               since_reached = '0;
               drive_q       = DRIVE_HALT;
               ev            = EV_REACHED;
            end
         end else if (moving && reached && since_reached <= settle_limit) begin
            ev = EV_SETTLE;
         end else begin
            rest_q = position_q;
            ev     = EV_UNEXPECTED;
         end
      end else if (moving && since_change > stall_limit) begin
         rest_q  = position_q;
         moving  = 1'b0;
         drive_q = DRIVE_HALT;
         ev      = EV_STALL;
      end

      // settle window over: the move ends quietly
      if (moving && reached && since_reached > settle_limit) begin
         moving = 1'b0;
         rest_q = position_q;
      end

      r.drive            = drive_q;
      r.command_accepted = accepted;
      r.in_motion        = moving;
      r.position_now     = position_q;
      r.rest_position    = rest_q;
      r.event_res        = ev;
      due_results.push_back(r);
   endtask

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         stall_limit   = STALL_TICKS_RESET;
         settle_limit  = SETTLE_TICKS_RESET;
         position_q    = '0;
         target_q      = '0;
         rest_q        = '0;
         dir_positive  = 1'b0;
         moving        = 1'b0;
         reached       = 1'b0;
         drive_q       = DRIVE_HALT;
         since_change  = '0;
         since_reached = '0;
         due_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_STALL_TICKS) stall_limit = csr_wdata;
            else if (csr_index == CSR_SETTLE_TICKS) settle_limit = csr_wdata;
         end
         if (req_tvalid && req_tready)
            predict_tick(req_tuser, req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               report_mismatch("result with no request due", '0, '0);
            end else begin
               want = due_results.pop_front();
               got  = result_type'(rsp_tdata[70:0]);
               if (got.drive !== want.drive)
                  report_mismatch("drive", 32'(got.drive), 32'(want.drive));
               if (got.command_accepted !== want.command_accepted)
                  report_mismatch("command_accepted", 32'(got.command_accepted),
                                  32'(want.command_accepted));
               if (got.in_motion !== want.in_motion)
                  report_mismatch("in_motion", 32'(got.in_motion), 32'(want.in_motion));
               if (got.position_now !== want.position_now)
                  report_mismatch("position_now", got.position_now, want.position_now);
               if (got.rest_position !== want.rest_position)
                  report_mismatch("rest_position", got.rest_position, want.rest_position);
               if (got.event_res !== want.event_res)
                  report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
               if (rsp_tdata[71] !== 1'b0)
                  report_mismatch("pad bit", 32'(rsp_tdata[71]), 32'd0);
            end
         end
      end
      pending = due_results.size();
   end

endmodule

// File: dv/tb_encoder_position_move_controller.sv
`timescale 1ns / 100ps

module tb_encoder_position_move_controller;
   import emp_pkg::*;

   localparam logic [1:0] OP_RESERVED  = 2'd3;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;
   localparam int         PHASE_TICKS  = 52;
   localparam int         PHASES       = 6;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;  // target_position [31:0], encoder_count [63:32]
   logic [1:0]  req_tuser;  // opcode [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   // drive [1:0], command_accepted [2], in_motion [3], position_now [35:4],
   // rest_position [67:36], event_res [70:68], zero [71]
   logic [71:0] rsp_tdata;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending;

   logic signed [31:0] enc_now;
   int                 ticks_sent;
   bit                 steady_send;
   bit                 steady_ready;
   int                 ready_left;

   encoder_position_move_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   encoder_position_move_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #10 clock = ~clock;

   // receiver back-pressure: mostly short stalls, now and then a long one
   always @(negedge clock) begin
      if (ready_left > 0) begin
         ready_left = ready_left - 1;
      end else if (steady_ready || $urandom_range(0, 99) < 60) begin
         rsp_tready <= 1'b1;
         ready_left = $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b0;
         ready_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                   : $urandom_range(10, 40);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_send || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // called and returns at a falling edge
   task automatic send_tick(input logic [1:0] op, input logic [31:0] tgt,
                            input logic [31:0] enc);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {enc, tgt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every request has its result
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic set_limits(input logic [31:0] stall, input logic [31:0] settle);
      drain();
      csr_write(CSR_STALL_TICKS, stall);
      csr_write(CSR_SETTLE_TICKS, settle);
      // spare indexes must leave both limits alone
      csr_write(CSR_SPARE_LO, $urandom);
      csr_write(CSR_SPARE_HI, $urandom);
      csr_wr_en <= 1'b0;
   endtask

   // a move request followed by encoder motion that mostly heads for the target
   task automatic run_move_episode(input int ticks);
      logic signed [31:0] aim;
      logic [1:0]         op;
      int                 roll;
      int                 offset;
      int                 step;
      roll = $urandom_range(0, 19);
      if (roll == 0) aim = 32'sh7FFF_FFFF;
      else if (roll == 1) aim = 32'sh8000_0000;
      else if (roll == 2) aim = enc_now;
      else begin
         offset = $urandom_range(0, 80);
         aim    = enc_now + offset - 40;
      end
      send_tick(OP_MOVE, aim, enc_now);
      for (int k = 0; k < ticks; k++) begin
         roll = $urandom_range(0, 99);
         step = $urandom_range(1, 8);
         op   = OP_NONE;
         if (roll < 55) begin
            if (aim > enc_now) enc_now = enc_now + step;
            else enc_now = enc_now - step;
         end else if (roll < 75) begin
            // no motion
         end else if (roll < 83) begin
            if (aim > enc_now) enc_now = enc_now - step;
            else enc_now = enc_now + step;
         end else if (roll < 88) op = OP_STOP;
         else if (roll < 92) op = OP_MOVE;
         else if (roll < 95) op = OP_RESERVED;
         else enc_now = $urandom;
         send_tick(op, $urandom, enc_now);
      end
      // still encoder, long enough to trip the stall limit now and then
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 14)) send_tick(OP_NONE, $urandom, enc_now);
   endtask

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int start;
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OP_NONE;
      rsp_tready   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_STALL_TICKS;
      csr_wdata    = '0;
      enc_now      = '0;
      ticks_sent   = 0;
      steady_send  = 1'b0;
      steady_ready = 1'b0;
      ready_left   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_limits(32'd2, 32'd1);
      send_tick(OP_NONE, 32'h0, 32'h0);
      send_tick(OP_RESERVED, 32'h5, 32'h0);
      // stop while idle is ignored
      send_tick(OP_STOP, 32'h0, 32'h0);
      send_tick(OP_NONE, 32'h0, 32'h3);
      // move to the held position goes negative
      send_tick(OP_MOVE, 32'h3, 32'h3);
      send_tick(OP_MOVE, 32'd100, 32'h3);
      send_tick(OP_NONE, 32'h0, 32'h2);
      send_tick(OP_NONE, 32'h0, 32'h1);
      send_tick(OP_NONE, 32'h0, 32'h1);
      // unreachable target, ends as a stall
      send_tick(OP_MOVE, 32'h7FFF_FFFF, 32'h1);
      send_tick(OP_NONE, 32'h0, 32'h1);
      send_tick(OP_NONE, 32'h0, 32'h1);
      send_tick(OP_NONE, 32'h0, 32'h1);
      send_tick(OP_MOVE, 32'h8000_0000, 32'h1);
      send_tick(OP_NONE, 32'h0, 32'h7FFF_FFFF);
      // stop retargets to the held position
      send_tick(OP_STOP, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_tick(OP_NONE, 32'h0, 32'h8000_0000);
      send_tick(OP_NONE, 32'h0, 32'h8000_0000);
      send_tick(OP_NONE, 32'h0, 32'h8000_0000);
      send_tick(OP_MOVE, 32'hFFFF_FFFF, 32'h8000_0000);
      send_tick(OP_NONE, 32'hFFFF_FFFF, 32'h0);
      send_tick(OP_NONE, 32'h0, 32'h0);
      send_tick(OP_NONE, 32'h0, 32'h0);
      enc_now = '0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_limits(32'd0, 32'd0);
            1: set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: set_limits(STALL_TICKS_RESET, SETTLE_TICKS_RESET);
            default: set_limits($urandom_range(0, 10), $urandom_range(0, 10));
         endcase
         steady_send  = (phase == 3) || ($urandom_range(0, 3) == 0);
         steady_ready = (phase == 3) || ($urandom_range(0, 3) == 0);
         start = ticks_sent;
         while (ticks_sent - start < PHASE_TICKS) begin
            run_move_episode($urandom_range(4, 30));
            if ($urandom_range(0, 9) == 0) drain();
         end
      end

      drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
